/* sv/dcbc_pkg.sv */
// Shared types, permutation tables, S-boxes and DES helper functions.
// No dependencies; imported by every module of the cascade cipher.
`timescale 1ns / 1ps
`default_nettype none
package dcbc_pkg;

    localparam int NUM_ROUNDS = 16;
    localparam int MAX_PASSES = 7;
    localparam int NUM_KEYS   = 4;
    localparam int NUM_STAGES = NUM_ROUNDS * MAX_PASSES;

    typedef enum logic [2:0] {
        REG_KEY_ONE   = 3'd0,
        REG_KEY_TWO   = 3'd1,
        REG_KEY_THREE = 3'd2,
        REG_KEY_FOUR  = 3'd3,
        REG_DEPTH     = 3'd4,
        REG_DECRYPT   = 3'd5,
        REG_PARITY_EN = 3'd6,
        REG_UNUSED    = 3'd7
    } dcbc_reg_t;

    typedef struct packed {
        logic skip;      // pass beyond the selected depth: carry data unchanged
        logic pass_end;  // last round of a pass: no half swap
    } dcbc_rnd_ctl_t;

    typedef logic [47:0] dcbc_subkey_t;

    localparam logic [5:0] IP_MAP [64] = '{
        6'd6, 6'd14, 6'd22, 6'd30, 6'd38, 6'd46, 6'd54, 6'd62,
        6'd4, 6'd12, 6'd20, 6'd28, 6'd36, 6'd44, 6'd52, 6'd60,
        6'd2, 6'd10, 6'd18, 6'd26, 6'd34, 6'd42, 6'd50, 6'd58,
        6'd0, 6'd8, 6'd16, 6'd24, 6'd32, 6'd40, 6'd48, 6'd56,
        6'd7, 6'd15, 6'd23, 6'd31, 6'd39, 6'd47, 6'd55, 6'd63,
        6'd5, 6'd13, 6'd21, 6'd29, 6'd37, 6'd45, 6'd53, 6'd61,
        6'd3, 6'd11, 6'd19, 6'd27, 6'd35, 6'd43, 6'd51, 6'd59,
        6'd1, 6'd9, 6'd17, 6'd25, 6'd33, 6'd41, 6'd49, 6'd57};

    localparam logic [5:0] FP_MAP [64] = '{
        6'd24, 6'd56, 6'd16, 6'd48, 6'd8, 6'd40, 6'd0, 6'd32,
        6'd25, 6'd57, 6'd17, 6'd49, 6'd9, 6'd41, 6'd1, 6'd33,
        6'd26, 6'd58, 6'd18, 6'd50, 6'd10, 6'd42, 6'd2, 6'd34,
        6'd27, 6'd59, 6'd19, 6'd51, 6'd11, 6'd43, 6'd3, 6'd35,
        6'd28, 6'd60, 6'd20, 6'd52, 6'd12, 6'd44, 6'd4, 6'd36,
        6'd29, 6'd61, 6'd21, 6'd53, 6'd13, 6'd45, 6'd5, 6'd37,
        6'd30, 6'd62, 6'd22, 6'd54, 6'd14, 6'd46, 6'd6, 6'd38,
        6'd31, 6'd63, 6'd23, 6'd55, 6'd15, 6'd47, 6'd7, 6'd39};

    localparam logic [4:0] E_MAP [48] = '{
        5'd0, 5'd31, 5'd30, 5'd29, 5'd28, 5'd27, 5'd28, 5'd27,
        5'd26, 5'd25, 5'd24, 5'd23, 5'd24, 5'd23, 5'd22, 5'd21,
        5'd20, 5'd19, 5'd20, 5'd19, 5'd18, 5'd17, 5'd16, 5'd15,
        5'd16, 5'd15, 5'd14, 5'd13, 5'd12, 5'd11, 5'd12, 5'd11,
        5'd10, 5'd9, 5'd8, 5'd7, 5'd8, 5'd7, 5'd6, 5'd5,
        5'd4, 5'd3, 5'd4, 5'd3, 5'd2, 5'd1, 5'd0, 5'd31};

    localparam logic [4:0] P_MAP [32] = '{
        5'd16, 5'd25, 5'd12, 5'd11, 5'd3, 5'd20, 5'd4, 5'd15,
        5'd31, 5'd17, 5'd9, 5'd6, 5'd27, 5'd14, 5'd1, 5'd22,
        5'd30, 5'd24, 5'd8, 5'd18, 5'd0, 5'd5, 5'd29, 5'd23,
        5'd13, 5'd19, 5'd2, 5'd26, 5'd10, 5'd21, 5'd28, 5'd7};

    localparam logic [5:0] PC1C_MAP [28] = '{
        6'd7, 6'd15, 6'd23, 6'd31, 6'd39, 6'd47, 6'd55, 6'd63,
        6'd6, 6'd14, 6'd22, 6'd30, 6'd38, 6'd46, 6'd54, 6'd62,
        6'd5, 6'd13, 6'd21, 6'd29, 6'd37, 6'd45, 6'd53, 6'd61,
        6'd4, 6'd12, 6'd20, 6'd28};

    localparam logic [5:0] PC1D_MAP [28] = '{
        6'd1, 6'd9, 6'd17, 6'd25, 6'd33, 6'd41, 6'd49, 6'd57,
        6'd2, 6'd10, 6'd18, 6'd26, 6'd34, 6'd42, 6'd50, 6'd58,
        6'd3, 6'd11, 6'd19, 6'd27, 6'd35, 6'd43, 6'd51, 6'd59,
        6'd36, 6'd44, 6'd52, 6'd60};

    localparam logic [5:0] PC2_MAP [48] = '{
        6'd42, 6'd39, 6'd45, 6'd32, 6'd55, 6'd51, 6'd53, 6'd28,
        6'd41, 6'd50, 6'd35, 6'd46, 6'd33, 6'd37, 6'd44, 6'd52,
        6'd30, 6'd48, 6'd40, 6'd49, 6'd29, 6'd36, 6'd43, 6'd54,
        6'd15, 6'd4, 6'd25, 6'd19, 6'd9, 6'd1, 6'd26, 6'd16,
        6'd5, 6'd11, 6'd23, 6'd8, 6'd12, 6'd7, 6'd17, 6'd0,
        6'd22, 6'd3, 6'd10, 6'd14, 6'd6, 6'd20, 6'd27, 6'd24};

    // cumulative left rotation of C and D after each round
    localparam logic [4:0] ROT_SUM [16] = '{
        5'd1, 5'd2, 5'd4, 5'd6, 5'd8, 5'd10, 5'd12, 5'd14,
        5'd15, 5'd17, 5'd19, 5'd21, 5'd23, 5'd25, 5'd27, 5'd28};

    // indexed directly by the 6-bit group
    localparam logic [3:0] SBOX [8][64] = '{
        '{4'd14, 4'd0, 4'd4, 4'd15, 4'd13, 4'd7, 4'd1, 4'd4,
          4'd2, 4'd14, 4'd15, 4'd2, 4'd11, 4'd13, 4'd8, 4'd1,
          4'd3, 4'd10, 4'd10, 4'd6, 4'd6, 4'd12, 4'd12, 4'd11,
          4'd5, 4'd9, 4'd9, 4'd5, 4'd0, 4'd3, 4'd7, 4'd8,
          4'd4, 4'd15, 4'd1, 4'd12, 4'd14, 4'd8, 4'd8, 4'd2,
          4'd13, 4'd4, 4'd6, 4'd9, 4'd2, 4'd1, 4'd11, 4'd7,
          4'd15, 4'd5, 4'd12, 4'd11, 4'd9, 4'd3, 4'd7, 4'd14,
          4'd3, 4'd10, 4'd10, 4'd0, 4'd5, 4'd6, 4'd0, 4'd13},
        '{4'd15, 4'd3, 4'd1, 4'd13, 4'd8, 4'd4, 4'd14, 4'd7,
          4'd6, 4'd15, 4'd11, 4'd2, 4'd3, 4'd8, 4'd4, 4'd14,
          4'd9, 4'd12, 4'd7, 4'd0, 4'd2, 4'd1, 4'd13, 4'd10,
          4'd12, 4'd6, 4'd0, 4'd9, 4'd5, 4'd11, 4'd10, 4'd5,
          4'd0, 4'd13, 4'd14, 4'd8, 4'd7, 4'd10, 4'd11, 4'd1,
          4'd10, 4'd3, 4'd4, 4'd15, 4'd13, 4'd4, 4'd1, 4'd2,
          4'd5, 4'd11, 4'd8, 4'd6, 4'd12, 4'd7, 4'd6, 4'd12,
          4'd9, 4'd0, 4'd3, 4'd5, 4'd2, 4'd14, 4'd15, 4'd9},
        '{4'd10, 4'd13, 4'd0, 4'd7, 4'd9, 4'd0, 4'd14, 4'd9,
          4'd6, 4'd3, 4'd3, 4'd4, 4'd15, 4'd6, 4'd5, 4'd10,
          4'd1, 4'd2, 4'd13, 4'd8, 4'd12, 4'd5, 4'd7, 4'd14,
          4'd11, 4'd12, 4'd4, 4'd11, 4'd2, 4'd15, 4'd8, 4'd1,
          4'd13, 4'd1, 4'd6, 4'd10, 4'd4, 4'd13, 4'd9, 4'd0,
          4'd8, 4'd6, 4'd15, 4'd9, 4'd3, 4'd8, 4'd0, 4'd7,
          4'd11, 4'd4, 4'd1, 4'd15, 4'd2, 4'd14, 4'd12, 4'd3,
          4'd5, 4'd11, 4'd10, 4'd5, 4'd14, 4'd2, 4'd7, 4'd12},
        '{4'd7, 4'd13, 4'd13, 4'd8, 4'd14, 4'd11, 4'd3, 4'd5,
          4'd0, 4'd6, 4'd6, 4'd15, 4'd9, 4'd0, 4'd10, 4'd3,
          4'd1, 4'd4, 4'd2, 4'd7, 4'd8, 4'd2, 4'd5, 4'd12,
          4'd11, 4'd1, 4'd12, 4'd10, 4'd4, 4'd14, 4'd15, 4'd9,
          4'd10, 4'd3, 4'd6, 4'd15, 4'd9, 4'd0, 4'd0, 4'd6,
          4'd12, 4'd10, 4'd11, 4'd1, 4'd7, 4'd13, 4'd13, 4'd8,
          4'd15, 4'd9, 4'd1, 4'd4, 4'd3, 4'd5, 4'd14, 4'd11,
          4'd5, 4'd12, 4'd2, 4'd7, 4'd8, 4'd2, 4'd4, 4'd14},
        '{4'd2, 4'd14, 4'd12, 4'd11, 4'd4, 4'd2, 4'd1, 4'd12,
          4'd7, 4'd4, 4'd10, 4'd7, 4'd11, 4'd13, 4'd6, 4'd1,
          4'd8, 4'd5, 4'd5, 4'd0, 4'd3, 4'd15, 4'd15, 4'd10,
          4'd13, 4'd3, 4'd0, 4'd9, 4'd14, 4'd8, 4'd9, 4'd6,
          4'd4, 4'd11, 4'd2, 4'd8, 4'd1, 4'd12, 4'd11, 4'd7,
          4'd10, 4'd1, 4'd13, 4'd14, 4'd7, 4'd2, 4'd8, 4'd13,
          4'd15, 4'd6, 4'd9, 4'd15, 4'd12, 4'd0, 4'd5, 4'd9,
          4'd6, 4'd10, 4'd3, 4'd4, 4'd0, 4'd5, 4'd14, 4'd3},
        '{4'd12, 4'd10, 4'd1, 4'd15, 4'd10, 4'd4, 4'd15, 4'd2,
          4'd9, 4'd7, 4'd2, 4'd12, 4'd6, 4'd9, 4'd8, 4'd5,
          4'd0, 4'd6, 4'd13, 4'd1, 4'd3, 4'd13, 4'd4, 4'd14,
          4'd14, 4'd0, 4'd7, 4'd11, 4'd5, 4'd3, 4'd11, 4'd8,
          4'd9, 4'd4, 4'd14, 4'd3, 4'd15, 4'd2, 4'd5, 4'd12,
          4'd2, 4'd9, 4'd8, 4'd5, 4'd12, 4'd15, 4'd3, 4'd10,
          4'd7, 4'd11, 4'd0, 4'd14, 4'd4, 4'd1, 4'd10, 4'd7,
          4'd1, 4'd6, 4'd13, 4'd0, 4'd11, 4'd8, 4'd6, 4'd13},
        '{4'd4, 4'd13, 4'd11, 4'd0, 4'd2, 4'd11, 4'd14, 4'd7,
          4'd15, 4'd4, 4'd0, 4'd9, 4'd8, 4'd1, 4'd13, 4'd10,
          4'd3, 4'd14, 4'd12, 4'd3, 4'd9, 4'd5, 4'd7, 4'd12,
          4'd5, 4'd2, 4'd10, 4'd15, 4'd6, 4'd8, 4'd1, 4'd6,
          4'd1, 4'd6, 4'd4, 4'd11, 4'd11, 4'd13, 4'd13, 4'd8,
          4'd12, 4'd1, 4'd3, 4'd4, 4'd7, 4'd10, 4'd14, 4'd7,
          4'd10, 4'd9, 4'd15, 4'd5, 4'd6, 4'd0, 4'd8, 4'd15,
          4'd0, 4'd14, 4'd5, 4'd2, 4'd9, 4'd3, 4'd2, 4'd12},
        '{4'd13, 4'd1, 4'd2, 4'd15, 4'd8, 4'd13, 4'd4, 4'd8,
          4'd6, 4'd10, 4'd15, 4'd3, 4'd11, 4'd7, 4'd1, 4'd4,
          4'd10, 4'd12, 4'd9, 4'd5, 4'd3, 4'd6, 4'd14, 4'd11,
          4'd5, 4'd0, 4'd0, 4'd14, 4'd12, 4'd9, 4'd7, 4'd2,
          4'd7, 4'd2, 4'd11, 4'd1, 4'd4, 4'd14, 4'd1, 4'd7,
          4'd9, 4'd4, 4'd12, 4'd10, 4'd14, 4'd8, 4'd2, 4'd13,
          4'd0, 4'd15, 4'd6, 4'd12, 4'd10, 4'd9, 4'd13, 4'd0,
          4'd15, 4'd3, 4'd3, 4'd5, 4'd5, 4'd6, 4'd8, 4'd11}
    };

    // output bit (n-1-i) takes input bit map[i]
    function automatic logic [63:0] perm_ip(input logic [63:0] v);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) r[63 - i] = v[IP_MAP[i]];
        return r;
    endfunction

    function automatic logic [63:0] perm_fp(input logic [63:0] v);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) r[63 - i] = v[FP_MAP[i]];
        return r;
    endfunction

    function automatic logic [31:0] feistel(input logic [31:0] half, input dcbc_subkey_t sk);
        logic [47:0] x;
        logic [31:0] s;
        logic [31:0] p;
        for (int i = 0; i < 48; i++) x[47 - i] = half[E_MAP[i]];
        x = x ^ sk;
        for (int i = 0; i < 8; i++) s[31 - 4 * i -: 4] = SBOX[i][x[47 - 6 * i -: 6]];
        for (int i = 0; i < 32; i++) p[31 - i] = s[P_MAP[i]];
        return p;
    endfunction

    // subkey of a given round (0..15) in forward order; round is a constant
    function automatic dcbc_subkey_t subkey(input logic [63:0] key, input int round);
        logic [27:0] c;
        logic [27:0] d;
        logic [55:0] cc;
        logic [55:0] dd;
        logic [55:0] cd;
        dcbc_subkey_t r;
        for (int i = 0; i < 28; i++) c[27 - i] = key[PC1C_MAP[i]];
        for (int i = 0; i < 28; i++) d[27 - i] = key[PC1D_MAP[i]];
        cc = {c, c} >> (28 - ROT_SUM[round]);
        dd = {d, d} >> (28 - ROT_SUM[round]);
        cd = {cc[27:0], dd[27:0]};
        for (int i = 0; i < 48; i++) r[47 - i] = cd[PC2_MAP[i]];
        return r;
    endfunction

    // true when some byte has even parity
    function automatic logic parity_bad(input logic [63:0] k);
        logic bad;
        bad = 1'b0;
        for (int i = 0; i < 8; i++) bad = bad | ~(^k[8 * i +: 8]);
        return bad;
    endfunction

endpackage
`default_nettype wire

/* sv/dcbc_keysched.sv */
// Key schedule: forward-order subkeys of all four key registers.
// Depends on dcbc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dcbc_keysched
    import dcbc_pkg::*;
(
    input  wire logic [63:0]  keys    [NUM_KEYS],
    output dcbc_subkey_t      subkeys [NUM_KEYS][NUM_ROUNDS]
);

    // fixed wiring per round: PC1, constant rotation, PC2
    always_comb
    begin
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            for (int j = 0; j < NUM_ROUNDS; j++)
            begin
                subkeys[k][j] = subkey(keys[k], j);
            end
        end
    end

endmodule
`default_nettype wire

/* sv/dcbc_round.sv */
// One registered DES round stage of the cascade pipeline.
// Depends on dcbc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dcbc_round
    import dcbc_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          valid_in,
    input  wire logic [31:0]   l_in,
    input  wire logic [31:0]   r_in,
    input  wire dcbc_subkey_t  sk,
    input  wire dcbc_rnd_ctl_t ctl,
    output logic               valid_out,
    output logic [31:0]        l_out,
    output logic [31:0]        r_out
);

    logic        valid_reg;
    logic [31:0] l_reg;
    logic [31:0] r_reg;
    logic [31:0] l_next;
    logic [31:0] r_next;
    logic [31:0] mix;

    always_comb
    begin
        mix = l_in ^ feistel(r_in, sk);
        if (ctl.skip)
        begin
            l_next = l_in;
            r_next = r_in;
        end
        else if (ctl.pass_end)
        begin
            // word handed on is {R16, L16}, which is what the next pass's IP sees
            l_next = mix;
            r_next = r_in;
        end
        else
        begin
            l_next = r_in;
            r_next = mix;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l_reg <= l_next;
            r_reg <= r_next;
        end
    end

    assign valid_out = valid_reg;
    assign l_out     = l_reg;
    assign r_out     = r_reg;

endmodule
`default_nettype wire

/* sv/des_cascade_block_cipher.sv */
// Top level: DES / 3-5-7 pass cascade cipher, ECB, fully unrolled pipeline.
// Depends on dcbc_pkg, dcbc_keysched, dcbc_round.
//
//  channel | signals                        | beat
//  input   | in_valid in_ready data_in      | one 64-bit block
//  output  | out_valid out_ready data_out   | block plus parity_error
//          | parity_error                   |
//  config  | cfg_valid cfg_ready cfg_index  | one register write
//          | cfg_data                       |
//
// The pipeline is an IP register, 112 round stages (7 passes x 16) and an
// output register with FP. Passes beyond the selected depth carry data unchanged.
// One block per cycle; the whole pipeline holds while the output beat waits.
// Reset clears valid bits and config (parity check on). cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none
module des_cascade_block_cipher
    import dcbc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [63:0] data_in,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [63:0]      data_out,
    output logic             parity_error,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    logic [63:0]   key_reg [NUM_KEYS];
    logic [1:0]    depth_reg;
    logic          decrypt_reg;
    logic          par_en_reg;

    dcbc_subkey_t  sched [NUM_KEYS][NUM_ROUNDS];
    dcbc_subkey_t  stage_sk  [NUM_STAGES];
    dcbc_rnd_ctl_t stage_ctl [NUM_STAGES];

    logic          v   [NUM_STAGES + 1];
    logic [31:0]   l   [NUM_STAGES + 1];
    logic [31:0]   r   [NUM_STAGES + 1];

    logic          v0_reg;
    logic [63:0]   ip_reg;
    logic          out_valid_reg;
    logic [63:0]   data_out_reg;
    logic          perr_reg;
    logic          perr;
    logic          en;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_KEYS; k++) key_reg[k] <= '0;
            depth_reg   <= '0;
            decrypt_reg <= 1'b0;
            par_en_reg  <= 1'b1;
        end
        else if (cfg_valid)
        begin
            unique case (dcbc_reg_t'(cfg_index))
                REG_KEY_ONE:   key_reg[0]  <= cfg_data;
                REG_KEY_TWO:   key_reg[1]  <= cfg_data;
                REG_KEY_THREE: key_reg[2]  <= cfg_data;
                REG_KEY_FOUR:  key_reg[3]  <= cfg_data;
                REG_DEPTH:     depth_reg   <= cfg_data[1:0];
                REG_DECRYPT:   decrypt_reg <= cfg_data[0];
                REG_PARITY_EN: par_en_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    dcbc_keysched u_keysched (
        .keys    (key_reg),
        .subkeys (sched)
    );

    // stage subkey, control; not enforced: keep static while blocks are in flight
    always_comb
    begin
        logic [3:0] npass;
        logic [2:0] kidx;
        logic       rev;
        npass = {1'b0, depth_reg, 1'b1};
        for (int p = 0; p < MAX_PASSES; p++)
        begin
            if (3'(p) <= {1'b0, depth_reg})
                kidx = 3'(p);
            else
                kidx = {depth_reg, 1'b0} - 3'(p);
            rev = decrypt_reg ^ kidx[0];
            for (int j = 0; j < NUM_ROUNDS; j++)
            begin
                stage_sk[p * NUM_ROUNDS + j] =
                    rev ? sched[kidx[1:0]][NUM_ROUNDS - 1 - j] : sched[kidx[1:0]][j];
                stage_ctl[p * NUM_ROUNDS + j].skip     = (4'(p) >= npass);
                stage_ctl[p * NUM_ROUNDS + j].pass_end = (j == NUM_ROUNDS - 1);
            end
        end
    end

    always_comb
    begin
        perr = 1'b0;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            if (2'(k) <= depth_reg) perr = perr | parity_bad(key_reg[k]);
        end
        perr = perr & par_en_reg;
    end

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg        <= in_valid;
            out_valid_reg <= v[NUM_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ip_reg       <= perm_ip(data_in);
            data_out_reg <= perr ? 64'd0 : perm_fp({l[NUM_STAGES], r[NUM_STAGES]});
            perr_reg     <= perr;
        end
    end

    assign v[0] = v0_reg;
    assign l[0] = ip_reg[63:32];
    assign r[0] = ip_reg[31:0];

    for (genvar s = 0; s < NUM_STAGES; s++)
    begin : g_round
        dcbc_round u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (v[s]),
            .l_in      (l[s]),
            .r_in      (r[s]),
            .sk        (stage_sk[s]),
            .ctl       (stage_ctl[s]),
            .valid_out (v[s + 1]),
            .l_out     (l[s + 1]),
            .r_out     (r[s + 1])
        );
    end

    assign out_valid    = out_valid_reg;
    assign data_out     = data_out_reg;
    assign parity_error = perr_reg;

endmodule
`default_nettype wire

/* sim/dcbc_checker.sv */
// Checker for the DES cascade cipher: follows the config, data-in and data-out channels,
// predicts each output beat and compares it field by field.
// Depends on dcbc_pkg for the register codes and the permutation and S-box tables.
`timescale 1ns / 1ps
module dcbc_checker
    import dcbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [63:0] data_in,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [63:0] data_out,
    input  logic        parity_error,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output int          fail_count,
    output int          blocks_pending
);

    typedef struct {
        logic [63:0] block;
        logic        perr;
    } cipher_out_t;

    cipher_out_t expected_blocks[$];

    logic [63:0] key_regs[4];
    logic [1:0]  depth_reg;
    logic        decrypt_reg;
    logic        parity_en_reg;

    assign blocks_pending = expected_blocks.size();

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
        fail_count++;
    endtask

    // one full 16-round DES pass; rev walks the subkeys backwards
    function automatic logic [63:0] des_pass(input logic [63:0] blk, input logic [63:0] key,
                                             input logic rev);
        logic [47:0] sks[16];
        logic [27:0] c;
        logic [27:0] d;
        logic [55:0] cd;
        logic [47:0] sk;
        logic [63:0] t;
        logic [31:0] l;
        logic [31:0] r;
        logic [31:0] s;
        logic [31:0] f;
        logic [31:0] nx;
        logic [47:0] x;
        int sh;
        for (int i = 0; i < 28; i++) c[27 - i] = key[PC1C_MAP[i]];
        for (int i = 0; i < 28; i++) d[27 - i] = key[PC1D_MAP[i]];
        for (int rnd = 0; rnd < 16; rnd++)
        begin
            sh = (rnd == 0 || rnd == 1 || rnd == 8 || rnd == 15) ? 1 : 2;
            c = (c << sh) | (c >> (28 - sh));
            d = (d << sh) | (d >> (28 - sh));
            cd = {c, d};
            for (int j = 0; j < 48; j++) sk[47 - j] = cd[PC2_MAP[j]];
            sks[rev ? 15 - rnd : rnd] = sk;
        end
        for (int i = 0; i < 64; i++) t[63 - i] = blk[IP_MAP[i]];
        l = t[63:32];
        r = t[31:0];
        for (int rnd = 0; rnd < 16; rnd++)
        begin
            for (int j = 0; j < 48; j++) x[47 - j] = r[E_MAP[j]];
            x = x ^ sks[rnd];
            for (int j = 0; j < 8; j++) s[31 - 4 * j -: 4] = SBOX[j][x[47 - 6 * j -: 6]];
            for (int j = 0; j < 32; j++) f[31 - j] = s[P_MAP[j]];
            nx = l ^ f;
            l = r;
            r = nx;
        end
        t = {r, l};
        for (int i = 0; i < 64; i++) blk[63 - i] = t[FP_MAP[i]];
        return blk;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        cipher_out_t exp_beat;
        cipher_out_t got;
        logic bad;
        int npass;
        int k;
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++) key_regs[i] <= '0;
            depth_reg     <= 2'd0;
            decrypt_reg   <= 1'b0;
            parity_en_reg <= 1'b1;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (dcbc_reg_t'(cfg_index))
                    REG_KEY_ONE:   key_regs[0]   <= cfg_data;
                    REG_KEY_TWO:   key_regs[1]   <= cfg_data;
                    REG_KEY_THREE: key_regs[2]   <= cfg_data;
                    REG_KEY_FOUR:  key_regs[3]   <= cfg_data;
                    REG_DEPTH:     depth_reg     <= cfg_data[1:0];
                    REG_DECRYPT:   decrypt_reg   <= cfg_data[0];
                    REG_PARITY_EN: parity_en_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                bad = 1'b0;
                if (parity_en_reg)
                    for (int i = 0; i <= depth_reg; i++)
                        for (int b = 0; b < 8; b++)
                            if (!(^key_regs[i][8 * b +: 8])) bad = 1'b1;
                exp_beat.perr  = bad;
                exp_beat.block = data_in;
                if (bad)
                    exp_beat.block = '0;
                else
                begin
                    npass = 2 * depth_reg + 1;
                    for (int i = 0; i < npass; i++)
                    begin
                        k = (i <= depth_reg) ? i : npass - 1 - i;
                        exp_beat.block = des_pass(exp_beat.block, key_regs[k],
                                                  decrypt_reg ^ k[0]);
                    end
                end
                expected_blocks.push_back(exp_beat);
            end
            if (out_valid && out_ready)
            begin
                if (expected_blocks.size() == 0)
                begin
                    $display("%0t output beat with nothing expected: %h", $realtime, data_out);
                    fail_count++;
                end
                else
                begin
                    got = expected_blocks.pop_front();
                    if (data_out !== got.block)
                        report_mismatch("data_out", data_out, got.block);
                    if (parity_error !== got.perr)
                        report_mismatch("parity_error", parity_error, got.perr);
                end
            end
        end
    end

    initial fail_count = 0;

endmodule

/* sim/tb_top.sv */
// Testbench top for des_cascade_block_cipher: clock, reset, config writes, block stimulus
// with random idling and back-pressure, and the verdict. Depends on dcbc_pkg, dcbc_checker, the DUT.
`timescale 1ns / 1ps
module tb_top;
    import dcbc_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [63:0] data_in;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] data_out;
    logic        parity_error;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    int          fail_count;
    int          blocks_pending;
    int          cycle_count;
    logic        hold_req;
    logic        hold_done;

    des_cascade_block_cipher uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .data_in(data_in),
        .out_valid(out_valid), .out_ready(out_ready),
        .data_out(data_out), .parity_error(parity_error),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    dcbc_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .data_in(data_in),
        .out_valid(out_valid), .out_ready(out_ready),
        .data_out(data_out), .parity_error(parity_error),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .blocks_pending(blocks_pending)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    always @(posedge clk) cycle_count <= cycle_count + 1;

    function automatic logic [63:0] odd_parity(input logic [63:0] k);
        for (int b = 0; b < 8; b++) k[8 * b] = ~^k[8 * b + 1 +: 7];
        return k;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 60) return 0;
        if (p < 94) return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    // caller is at a rising edge; returns at the edge that accepted the beat
    task automatic send_block(input logic [63:0] d, input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        data_in  <= d;
        @(negedge clk);
        while (!in_ready) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (blocks_pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input dcbc_reg_t idx, input logic [63:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(negedge clk);
        while (!cfg_ready) @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_all(input logic [63:0] k1, input logic [63:0] k2,
                           input logic [63:0] k3, input logic [63:0] k4,
                           input logic [1:0] depth, input logic dec, input logic pen);
        wait_idle();
        write_reg(REG_KEY_ONE, k1);
        write_reg(REG_KEY_TWO, k2);
        write_reg(REG_KEY_THREE, k3);
        write_reg(REG_KEY_FOUR, k4);
        write_reg(REG_DEPTH, {62'd0, depth});
        write_reg(REG_DECRYPT, {63'd0, dec});
        write_reg(REG_PARITY_EN, {63'd0, pen});
    endtask

    function automatic logic [63:0] rand_block();
        int p;
        p = $urandom_range(99);
        if (p < 3) return '0;
        if (p < 6) return '1;
        return rand64();
    endfunction

    function automatic logic [63:0] rand_key();
        // mostly well-formed keys so that the cipher path is exercised
        if ($urandom_range(99) < 88) return odd_parity(rand64());
        return rand64();
    endfunction

    // receiver: random stalls, plus long hold-offs to back the pipeline up
    initial
    begin : receiver
        int n;
        hold_done = 1'b0;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_done = 1'b1;
            end
            if (cycle_count > 6000 && cycle_count < 6100 ||
                cycle_count > 14000 && cycle_count < 14100)
            begin
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            n = $urandom_range(99);
            if (n < 70)
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
            else if (n < 95)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(10, 40)) @(posedge clk);
            end
        end
    end

    initial
    begin
        #3_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : stimulus
        logic [63:0] k1;
        int items;
        cycle_count = 0;
        hold_req    = 1'b0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        data_in   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_KEY_ONE;
        cfg_data  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset config: zero keys fail the parity check
        send_block('0, 0);
        send_block('1, 0);

        // single DES, both directions, extreme blocks
        k1 = 64'h1334_5779_9BBC_DFF1;
        set_all(k1, '0, '0, '0, 2'd0, 1'b0, 1'b1);
        send_block(64'h0123_4567_89AB_CDEF, 0);
        send_block('0, 0);
        send_block('1, 1);
        send_block(64'hAAAA_AAAA_5555_5555, 0);
        wait_idle();
        write_reg(REG_UNUSED, '1);
        write_reg(REG_DECRYPT, 64'd1);
        send_block(64'h85E8_1354_0F0A_B405, 0);
        send_block('1, 0);

        // a bad key beyond the depth is not checked
        set_all(odd_parity('1), odd_parity(64'h5A5A_5A5A_5A5A_5A5A), '1, '0,
                2'd1, 1'b0, 1'b1);
        send_block(64'hFEDC_BA98_7654_3210, 0);
        send_block('0, 0);
        // deepest cascade with a bad fourth key
        set_all(odd_parity('1), odd_parity('0), odd_parity(64'h0F0F_0F0F_F0F0_F0F0), '1,
                2'd3, 1'b1, 1'b1);
        send_block('1, 0);
        send_block(64'h8000_0000_0000_0001, 0);
        // parity check off: raw keys go straight into the schedule
        wait_idle();
        write_reg(REG_PARITY_EN, 64'd0);
        send_block('1, 0);
        send_block('0, 0);
        set_all('1, '0, '1, '0, 2'd2, 1'b0, 1'b0);
        send_block(64'h0123_4567_89AB_CDEF, 0);
        send_block('1, 0);

        // long receiver hold-off while blocks keep coming back to back
        items = 0;
        set_all(odd_parity(rand64()), odd_parity(rand64()), '0, '0, 2'd1, 1'b0, 1'b1);
        hold_req = 1'b1;
        repeat (150)
        begin
            send_block(rand_block(), 0);
            items++;
        end

        while (items < 1100)
        begin
            set_all(rand_key(), rand_key(), rand_key(), rand_key(),
                    2'($urandom_range(3)), 1'($urandom_range(1)),
                    $urandom_range(99) < 80);
            repeat ($urandom_range(30, 90))
            begin
                send_block(rand_block(), gap_len());
                items++;
            end
        end

        wait_idle();
        repeat (130) @(posedge clk);
        if (fail_count == 0 && blocks_pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* sim.f */
sv/dcbc_pkg.sv
sv/dcbc_keysched.sv
sv/dcbc_round.sv
sv/des_cascade_block_cipher.sv
sim/dcbc_checker.sv
sim/tb_top.sv
